/* rtl/belu_pkg.sv */
package belu_pkg;

	// Operation carried by an input beat.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// Result status codes.
	localparam logic [1:0] STAT_QUERY  = 2'd0;
	localparam logic [1:0] STAT_INSERT = 2'd1;
	localparam logic [1:0] STAT_FULL   = 2'd2;

	// Segment shapes; the fourth code behaves as linear.
	localparam logic [1:0] SHAPE_LINEAR = 2'd0;
	localparam logic [1:0] SHAPE_SQUARE = 2'd1;
	localparam logic [1:0] SHAPE_SQRT   = 2'd2;

	localparam int TIME_W  = 32;
	localparam int VALUE_W = 16;

	// One stored breakpoint.
	typedef struct packed {
		logic [TIME_W-1:0]  ptime;
		logic [VALUE_W-1:0] pvalue;
		logic [1:0]         shape;
	} entry_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_INS_WR,
		ST_LEFT_RD,
		ST_LEFT,
		ST_DIV,
		ST_SQUARE,
		ST_SQRT,
		ST_SCALE,
		ST_DONE
	} state_t;

endpackage

/* rtl/belu_store.sv */
module belu_store #(
	parameter int MAX_POINTS = 16
) (
	input  logic                          clk,
	input  logic [$clog2(MAX_POINTS)-1:0] rd_addr,
	output belu_pkg::entry_t              rd_data,
	input  logic                          wr_en,
	input  logic [$clog2(MAX_POINTS)-1:0] wr_addr,
	input  belu_pkg::entry_t              wr_data
);

	belu_pkg::entry_t mem_q [MAX_POINTS];
	belu_pkg::entry_t rd_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

/* rtl/belu_div.sv */
module belu_div #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [31:0]              num,
	input  logic [31:0]              den,
	output logic                     done,
	output logic [FRACTION_BITS:0]   quo
);

	localparam int CNT_W = $clog2(FRACTION_BITS + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [31:0]       rem_q;
	logic [31:0]       den_q;
	logic [FRACTION_BITS:0] quo_q;
	logic [32:0]       r2;
	logic              ge;
	logic              ge0;

	assign ge0 = (num >= den);
	assign r2  = {rem_q, 1'b0};
	assign ge  = (r2 >= {1'b0, den_q});

	// Iteration control: one quotient bit per cycle after the first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRACTION_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring division datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= ge0 ? (num - den) : num;
			quo_q <= {{FRACTION_BITS{1'b0}}, ge0};
		end else if (busy_q) begin
			rem_q <= ge ? 32'(r2 - {1'b0, den_q}) : r2[31:0];
			quo_q <= {quo_q[FRACTION_BITS-1:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* rtl/belu_sqrt.sv */
module belu_sqrt #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [FRACTION_BITS:0] frac,
	output logic                   done,
	output logic [FRACTION_BITS:0] root
);

	localparam int BW    = FRACTION_BITS + 1;
	localparam int XW    = 2 * BW;
	localparam int RW    = FRACTION_BITS + 3;
	localparam int CNT_W = $clog2(BW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [XW-1:0]    xs_q;
	logic [RW-1:0]    rem_q;
	logic [BW-1:0]    root_q;
	logic [RW+1:0]    cand;
	logic [RW+1:0]    trial;
	logic             ge;

	assign cand  = {rem_q, xs_q[XW-1 -: 2]};
	assign trial = (RW+2)'({root_q, 2'b01});
	assign ge    = (cand >= trial);

	// Iteration control: one root bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(BW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The radicand is the fraction scaled up by the fraction width; two bits enter each step.
	always_ff @(posedge clk) begin
		if (start) begin
			xs_q   <= {1'b0, frac, {FRACTION_BITS{1'b0}}};
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			xs_q   <= {xs_q[XW-3:0], 2'b00};
			rem_q  <= ge ? RW'(cand - trial) : RW'(cand);
			root_q <= {root_q[BW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* rtl/belu_mul.sv */
module belu_mul #(
	parameter int AW = 18,
	parameter int BW = 17
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [AW-1:0]   a,
	input  logic [BW-1:0]          b,
	output logic                   done,
	output logic signed [AW+BW-1:0] prod
);

	localparam int PW    = AW + BW;
	localparam int CNT_W = $clog2(BW + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic signed [PW-1:0] acc_q;
	logic signed [PW-1:0] ash_q;
	logic [BW-1:0]        b_q;

	// Iteration control: one multiplier bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(BW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift-and-add over the unsigned multiplier, least significant bit first.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			ash_q <= PW'(a);
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + ash_q;
			end
			ash_q <= ash_q <<< 1;
			b_q   <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

/* rtl/breakpoint_envelope_lookup_unit.sv */
// Breakpoint envelope lookup: one automation lane of up to MAX_POINTS time-sorted points.
// Input channel (in_valid / in_stall): opcode, point_time, point_value, curve_shape.
// An insert places the point after all stored points of equal or earlier time; a
// query returns the interpolated value at point_time. Output channel (out_valid /
// out_stall) carries one beat per input beat: result_value and status.
// Configuration channel (cfg_valid / cfg_ready, always ready) writes default_value,
// the answer to a query on an empty lane; write it only while the block is idle.
// One item is worked on at a time; in_stall is high from acceptance until the result
// has moved into the output register, then low until the next beat is taken.
// Steps per item: an insert on an empty lane writes the point without a scan; else it
// scans the single-port table entry by entry (a read and a check state each), then
// shifts later entries up one at a time (a read and a write state each) and writes the
// new point. An insert on a full lane is dropped without a scan. A query on an empty
// lane answers with the default value; before the first or after the last point it
// answers from the scan; between points the scan is followed by a read of the left point,
// the divider, for a square or square-root shape a squaring multiply or the root, and the
// scaling multiply; divider, square root and multiplier are bit-serial, one bit a cycle.
// The output register holds a finished beat while out_stall is high; the next item may
// be accepted meanwhile and waits before its own result is presented.
// Reset clears the point count, the default value and all handshake state.
module breakpoint_envelope_lookup_unit #(
	parameter int MAX_POINTS    = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               opcode,
	input  logic [31:0]        point_time,
	input  logic signed [15:0] point_value,
	input  logic [1:0]         curve_shape,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] result_value,
	output logic [1:0]         status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic signed [15:0] default_value
);

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int BW = FRACTION_BITS + 1;
	localparam int AW = (FRACTION_BITS + 2 > 17) ? FRACTION_BITS + 2 : 17;
	localparam int PW = AW + BW;

	belu_pkg::state_t state_q, state_nx;

	logic [CW-1:0]      count_q;
	logic [15:0]        dflt_q;
	logic               op_q;
	logic [31:0]        t_q;
	logic [15:0]        pv_q;
	logic [1:0]         sh_q;
	logic [IW-1:0]      idx_q;
	logic [IW-1:0]      pos_q;
	logic [IW-1:0]      k_q;
	logic [31:0]        t2_q;
	logic [15:0]        v1_q;
	logic [15:0]        v2_q;
	logic [1:0]         lshape_q;
	logic [15:0]        res_q;
	logic [1:0]         stat_q;
	logic               out_valid_q;
	logic [15:0]        out_value_q;
	logic [1:0]         out_status_q;

	logic               in_acc;
	logic               out_free;
	logic               found;
	logic               last_idx;
	logic               count_zero;
	logic               full;

	logic [IW-1:0]      rd_addr;
	belu_pkg::entry_t   rd_data;
	logic               wr_en;
	logic [IW-1:0]      wr_addr;
	belu_pkg::entry_t   wr_data;

	logic               div_start;
	logic               div_done;
	logic [31:0]        div_num;
	logic [31:0]        div_den;
	logic [BW-1:0]      frac;
	logic               sqrt_start;
	logic               sqrt_done;
	logic [BW-1:0]      root;
	logic               mul_start;
	logic               mul_done;
	logic signed [AW-1:0] mul_a;
	logic [BW-1:0]      mul_b;
	logic signed [PW-1:0] prod;
	logic signed [16:0] diff;

	assign in_acc     = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign count_zero = (count_q == '0);
	assign full       = (count_q >= CW'(MAX_POINTS));
	assign last_idx   = ((CW'(idx_q) + 1'b1) == count_q);
	assign found      = (op_q == belu_pkg::OP_INSERT) ? (rd_data.ptime > t_q)
	                                                  : (rd_data.ptime >= t_q);
	assign diff       = 17'(signed'(v2_q)) - 17'(signed'(v1_q));

	belu_store #(.MAX_POINTS(MAX_POINTS)) u_store (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	belu_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (frac)
	);

	belu_sqrt #(.FRACTION_BITS(FRACTION_BITS)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.frac   (frac),
		.done   (sqrt_done),
		.root   (root)
	);

	belu_mul #(.AW(AW), .BW(BW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	// Next-state logic of the sequencer.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			belu_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (opcode == belu_pkg::OP_QUERY) begin
						state_nx = count_zero ? belu_pkg::ST_DONE : belu_pkg::ST_SCAN_RD;
					end else if (full) begin
						state_nx = belu_pkg::ST_DONE;
					end else begin
						state_nx = count_zero ? belu_pkg::ST_SHIFT_RD : belu_pkg::ST_SCAN_RD;
					end
				end
			end
			belu_pkg::ST_SCAN_RD: state_nx = belu_pkg::ST_SCAN_CHK;
			belu_pkg::ST_SCAN_CHK: begin
				if (op_q == belu_pkg::OP_INSERT) begin
					state_nx = (found || last_idx) ? belu_pkg::ST_SHIFT_RD
					                               : belu_pkg::ST_SCAN_RD;
				end else if (found) begin
					state_nx = (idx_q == '0) ? belu_pkg::ST_DONE : belu_pkg::ST_LEFT_RD;
				end else begin
					state_nx = last_idx ? belu_pkg::ST_DONE : belu_pkg::ST_SCAN_RD;
				end
			end
			belu_pkg::ST_SHIFT_RD: begin
				state_nx = (k_q == pos_q) ? belu_pkg::ST_INS_WR : belu_pkg::ST_SHIFT_WR;
			end
			belu_pkg::ST_SHIFT_WR: state_nx = belu_pkg::ST_SHIFT_RD;
			belu_pkg::ST_INS_WR:   state_nx = belu_pkg::ST_DONE;
			belu_pkg::ST_LEFT_RD:  state_nx = belu_pkg::ST_LEFT;
			belu_pkg::ST_LEFT:     state_nx = belu_pkg::ST_DIV;
			belu_pkg::ST_DIV: begin
				if (div_done) begin
					case (lshape_q)
						belu_pkg::SHAPE_SQUARE: state_nx = belu_pkg::ST_SQUARE;
						belu_pkg::SHAPE_SQRT:   state_nx = belu_pkg::ST_SQRT;
						default:                state_nx = belu_pkg::ST_SCALE;
					endcase
				end
			end
			belu_pkg::ST_SQUARE: if (mul_done) state_nx = belu_pkg::ST_SCALE;
			belu_pkg::ST_SQRT:   if (sqrt_done) state_nx = belu_pkg::ST_SCALE;
			belu_pkg::ST_SCALE:  if (mul_done) state_nx = belu_pkg::ST_DONE;
			belu_pkg::ST_DONE:   if (out_free) state_nx = belu_pkg::ST_IDLE;
			default:             state_nx = belu_pkg::ST_IDLE;
		endcase
	end

	// Table access and unit control for the current state.
	always_comb begin
		rd_addr    = idx_q;
		wr_en      = 1'b0;
		wr_addr    = k_q;
		wr_data    = rd_data;
		div_start  = 1'b0;
		div_num    = t_q - rd_data.ptime;
		div_den    = t2_q - rd_data.ptime;
		sqrt_start = 1'b0;
		mul_start  = 1'b0;
		mul_a      = AW'(diff);
		mul_b      = frac;
		case (state_q)
			belu_pkg::ST_SHIFT_RD: rd_addr = k_q - 1'b1;
			belu_pkg::ST_SHIFT_WR: wr_en = 1'b1;
			belu_pkg::ST_INS_WR: begin
				wr_en   = 1'b1;
				wr_addr = pos_q;
				wr_data = '{ptime: t_q, pvalue: pv_q, shape: sh_q};
			end
			belu_pkg::ST_LEFT_RD: rd_addr = idx_q - 1'b1;
			belu_pkg::ST_LEFT:    div_start = 1'b1;
			belu_pkg::ST_DIV: begin
				if (div_done) begin
					case (lshape_q)
						belu_pkg::SHAPE_SQUARE: begin
							mul_start = 1'b1;
							mul_a     = AW'(signed'({1'b0, frac}));
						end
						belu_pkg::SHAPE_SQRT: sqrt_start = 1'b1;
						default:              mul_start = 1'b1;
					endcase
				end
			end
			belu_pkg::ST_SQUARE: begin
				mul_start = mul_done;
				mul_b     = prod[FRACTION_BITS +: BW];
			end
			belu_pkg::ST_SQRT: begin
				mul_start = sqrt_done;
				mul_b     = root;
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= belu_pkg::ST_IDLE;
			count_q     <= '0;
			dflt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				dflt_q <= default_value;
			end
			if (state_q == belu_pkg::ST_INS_WR) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == belu_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item, scan and result registers.
	always_ff @(posedge clk) begin
		case (state_q)
			belu_pkg::ST_IDLE: begin
				op_q  <= opcode;
				t_q   <= point_time;
				pv_q  <= point_value;
				sh_q  <= curve_shape;
				idx_q <= '0;
				pos_q <= '0;
				k_q   <= '0;
				res_q <= '0;
				if (opcode == belu_pkg::OP_QUERY) begin
					stat_q <= belu_pkg::STAT_QUERY;
					res_q  <= dflt_q;
				end else begin
					stat_q <= full ? belu_pkg::STAT_FULL : belu_pkg::STAT_INSERT;
				end
			end
			belu_pkg::ST_SCAN_CHK: begin
				if (op_q == belu_pkg::OP_INSERT) begin
					if (found) begin
						pos_q <= idx_q;
					end else begin
						pos_q <= IW'(count_q);
					end
					k_q <= IW'(count_q);
				end else begin
					res_q <= rd_data.pvalue;
					t2_q  <= rd_data.ptime;
					v2_q  <= rd_data.pvalue;
				end
				if (!found && !last_idx) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			belu_pkg::ST_SHIFT_WR: k_q <= k_q - 1'b1;
			belu_pkg::ST_LEFT: begin
				v1_q     <= rd_data.pvalue;
				lshape_q <= rd_data.shape;
			end
			belu_pkg::ST_SCALE: begin
				res_q <= 16'(prod[FRACTION_BITS +: 16] + v1_q);
			end
			default: ;
		endcase
		if (state_q == belu_pkg::ST_DONE && out_free) begin
			out_value_q  <= res_q;
			out_status_q <= stat_q;
		end
	end

	assign in_stall     = (state_q != belu_pkg::ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign result_value = out_value_q;
	assign status       = out_status_q;

endmodule

/* rtl/belu_checker.sv */
module belu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] result_value,
	input logic [1:0]  status
);

	// A stalled beat holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_value) && $stable(status))
		else $error("stalled result beat changed");

	// Status never carries the unused code.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("result status out of range");

	// Insert and full-lane results carry a zero value.
	a_insert_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 2'd0 |-> result_value == 16'd0)
		else $error("insert result with non-zero value");

	// An accepted item keeps the input side stalled for at least the following cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while item still in progress");

endmodule

bind breakpoint_envelope_lookup_unit belu_checker u_belu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.result_value (result_value),
	.status       (status)
);

/* tb/tb_breakpoint_envelope_lookup_unit.sv */
module tb_breakpoint_envelope_lookup_unit;

	localparam int LANE_DEPTH = 16;
	localparam int FRAC = 16;
	localparam logic [1:0] SHAPE_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 1000;

	typedef struct {
		logic              op;
		logic [31:0]       ptime;
		logic signed [15:0] pvalue;
		logic [1:0]        shape;
	} lane_req_t;

	typedef struct {
		logic signed [15:0] value;
		logic [1:0]         stat;
	} lane_resp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = belu_pkg::OP_INSERT;
	logic [31:0] point_time = '0;
	logic signed [15:0] point_value = '0;
	logic [1:0] curve_shape = belu_pkg::SHAPE_LINEAR;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] result_value;
	logic [1:0] status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic signed [15:0] default_value = '0;

	// Shadow copy of the lane, updated as beats are accepted.
	logic [31:0]        lane_time [LANE_DEPTH];
	logic signed [15:0] lane_val [LANE_DEPTH];
	logic [1:0]         lane_shape [LANE_DEPTH];
	int                 lane_count = 0;
	logic signed [15:0] lane_default = '0;

	lane_req_t  pending_reqs [$];
	lane_resp_t awaited_resps [$];
	lane_req_t  next_req;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fail_count = 0;
	int quiet_cycles = 0;
	logic hold_arm = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;

	breakpoint_envelope_lookup_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .point_time(point_time),
		.point_value(point_value), .curve_shape(curve_shape),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_value(result_value), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.default_value(default_value)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Appends a beat to the queue of items still to be offered.
	function automatic void queue_req(input lane_req_t rq);
		pending_reqs = {pending_reqs, rq};
	endfunction

	// Appends an answer to the queue of results still to arrive.
	function automatic void expect_resp(input lane_resp_t rs);
		awaited_resps = {awaited_resps, rs};
	endfunction

	// Integer square root, one result bit per step from the top.
	function automatic longint int_sqrt(input longint x);
		longint r;
		longint cand;
		r = 0;
		for (int b = 17; b >= 0; b--) begin
			cand = r | (longint'(1) << b);
			if (cand * cand <= x)
				r = cand;
		end
		return r;
	endfunction

	// Value of the lane at time t, interpolated between the bracketing points.
	function automatic logic signed [15:0] lane_value_at(input logic [31:0] t);
		int hi;
		longint f;
		longint g;
		longint d;
		longint p;
		logic [31:0] span;
		logic [31:0] offs;
		if (lane_count == 0)
			return lane_default;
		hi = lane_count;
		for (int i = 0; i < lane_count; i++) begin
			if (lane_time[i] >= t) begin
				hi = i;
				break;
			end
		end
		if (hi == 0)
			return lane_val[0];
		if (hi >= lane_count)
			return lane_val[lane_count - 1];
		span = lane_time[hi] - lane_time[hi - 1];
		offs = t - lane_time[hi - 1];
		f = (longint'({32'd0, offs}) << FRAC) / longint'({32'd0, span});
		if (f > (longint'(1) << FRAC))
			f = longint'(1) << FRAC;
		case (lane_shape[hi - 1])
			belu_pkg::SHAPE_SQUARE: g = (f * f) >> FRAC;
			belu_pkg::SHAPE_SQRT:   g = int_sqrt(f << FRAC);
			default:                g = f;
		endcase
		d = longint'(lane_val[hi]) - longint'(lane_val[hi - 1]);
		p = d * g;
		// Arithmetic shift floors towards minus infinity.
		return 16'(longint'(lane_val[hi - 1]) + (p >>> FRAC));
	endfunction

	// Applies one beat to the shadow lane and returns the answer it should produce.
	function automatic lane_resp_t lane_apply(input lane_req_t rq);
		lane_resp_t rs;
		int pos;
		rs.value = '0;
		if (rq.op == belu_pkg::OP_QUERY) begin
			rs.value = lane_value_at(rq.ptime);
			rs.stat = belu_pkg::STAT_QUERY;
		end else if (lane_count >= LANE_DEPTH) begin
			rs.stat = belu_pkg::STAT_FULL;
		end else begin
			pos = 0;
			while (pos < lane_count && lane_time[pos] <= rq.ptime)
				pos++;
			for (int k = lane_count; k > pos; k--) begin
				lane_time[k] = lane_time[k - 1];
				lane_val[k] = lane_val[k - 1];
				lane_shape[k] = lane_shape[k - 1];
			end
			lane_time[pos] = rq.ptime;
			lane_val[pos] = rq.pvalue;
			lane_shape[pos] = rq.shape;
			lane_count++;
			rs.stat = belu_pkg::STAT_INSERT;
		end
		return rs;
	endfunction

	// Input driver: predicts on acceptance, then offers the next queued beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expect_resp(lane_apply(next_req));
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req = pending_reqs.pop_front();
					in_valid <= 1'b1;
					opcode <= next_req.op;
					point_time <= next_req.ptime;
					point_value <= next_req.pvalue;
					curve_shape <= next_req.shape;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each beat against the oldest expected answer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_resps.size() == 0) begin
					$error("result beat with nothing expected: value %0d status %0d",
						result_value, status);
					fail_count++;
				end else begin
					if (result_value !== awaited_resps[0].value) begin
						$error("result_value: expected %0d, got %0d",
							awaited_resps[0].value, result_value);
						fail_count++;
					end
					if (status !== awaited_resps[0].stat) begin
						$error("status: expected %0d, got %0d", awaited_resps[0].stat, status);
						fail_count++;
					end
					void'(awaited_resps.pop_front());
				end
			end
			out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Long receiver hold-off, armed once, so that the block backs up its input.
	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
		else if (hold_arm && !hold_done) begin
			hold_left <= 600;
			hold_done <= 1'b1;
		end
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic lane_req_t make_req(input logic op, input logic [31:0] t,
			input logic signed [15:0] v, input logic [1:0] s);
		lane_req_t rq;
		rq.op = op;
		rq.ptime = t;
		rq.pvalue = v;
		rq.shape = s;
		return rq;
	endfunction

	task automatic drain_lane();
		while (pending_reqs.size() > 0 || in_valid || awaited_resps.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_default(input logic signed [15:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		default_value <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		lane_default = v;
	endtask

	// Random query time, mostly inside or on the edges of stored segments.
	function automatic logic [31:0] pick_query_time();
		int i;
		logic [31:0] span;
		i = $urandom_range(LANE_DEPTH - 1);
		case ($urandom_range(9))
			0: return $urandom;
			1: return lane_time[i];
			2: return lane_time[i] + 32'd1;
			3: return ($urandom_range(1)) ? 32'hFFFF_FFFF : 32'd0;
			default: begin
				if (i == LANE_DEPTH - 1)
					return lane_time[i] - $urandom_range(3);
				span = lane_time[i + 1] - lane_time[i];
				return lane_time[i] + ((span == 0) ? 32'd0 : ($urandom % span) + 32'd1);
			end
		endcase
	endfunction

	initial begin
		send_idle_pct = 18;
		recv_idle_pct = 59;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Empty lane answers with the default value, at both extremes and one random.
		write_default(16'sh8000);
		queue_req(make_req(belu_pkg::OP_QUERY, 32'd0, 16'sd0, belu_pkg::SHAPE_LINEAR));
		drain_lane();
		write_default(16'sh7FFF);
		queue_req(make_req(belu_pkg::OP_QUERY, 32'hFFFF_FFFF, 16'sd0,
			belu_pkg::SHAPE_LINEAR));
		drain_lane();
		write_default(16'($urandom));
		queue_req(make_req(belu_pkg::OP_QUERY, $urandom, 16'sd0, belu_pkg::SHAPE_LINEAR));
		drain_lane();

		// Directed inserts: extreme times and values, every shape, equal times.
		queue_req(make_req(belu_pkg::OP_INSERT, 32'd5000, 16'sd100, belu_pkg::SHAPE_LINEAR));
		queue_req(make_req(belu_pkg::OP_QUERY, 32'd7, 16'sd0, belu_pkg::SHAPE_LINEAR));
		queue_req(make_req(belu_pkg::OP_INSERT, 32'd0, 16'sh8000, belu_pkg::SHAPE_SQUARE));
		queue_req(make_req(belu_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'sh7FFF,
			belu_pkg::SHAPE_SQRT));
		queue_req(make_req(belu_pkg::OP_INSERT, 32'd5000, -16'sd200, SHAPE_SPARE));
		queue_req(make_req(belu_pkg::OP_INSERT, 32'd5000, 16'sd300, belu_pkg::SHAPE_SQRT));
		queue_req(make_req(belu_pkg::OP_INSERT, 32'd9000, 16'sh7FFF,
			belu_pkg::SHAPE_LINEAR));
		queue_req(make_req(belu_pkg::OP_QUERY, 32'd5000, 16'sd0, belu_pkg::SHAPE_LINEAR));
		queue_req(make_req(belu_pkg::OP_QUERY, 32'd2500, 16'sd0, belu_pkg::SHAPE_LINEAR));
		queue_req(make_req(belu_pkg::OP_QUERY, 32'd0, 16'sd0, belu_pkg::SHAPE_LINEAR));
		queue_req(make_req(belu_pkg::OP_QUERY, 32'd7000, 16'sd0, belu_pkg::SHAPE_LINEAR));
		queue_req(make_req(belu_pkg::OP_QUERY, 32'd9001, 16'sd0, belu_pkg::SHAPE_LINEAR));
		queue_req(make_req(belu_pkg::OP_QUERY, 32'hFFFF_FFFF, 16'sd0,
			belu_pkg::SHAPE_LINEAR));
		queue_req(make_req(belu_pkg::OP_QUERY, 32'hFFFF_FFFE, 16'sd0,
			belu_pkg::SHAPE_LINEAR));
		// Fill the rest of the table with random points.
		for (int n = 6; n < LANE_DEPTH; n++)
			queue_req(make_req(belu_pkg::OP_INSERT, $urandom, 16'($urandom),
				2'($urandom)));
		// The table is now full, so this one is dropped.
		queue_req(make_req(belu_pkg::OP_INSERT, 32'd1, 16'sd1, belu_pkg::SHAPE_LINEAR));
		drain_lane();

		// Random part in three idling regimes; mostly queries on the full lane.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 59 : 0;
			recv_idle_pct = (ph == 0) ? 59 : (ph == 1) ? 18 : 0;
			for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
				if ($urandom_range(9) == 0)
					queue_req(make_req(belu_pkg::OP_INSERT, $urandom, 16'($urandom),
						2'($urandom)));
				else
					queue_req(make_req(belu_pkg::OP_QUERY, pick_query_time(),
						16'($urandom), 2'($urandom)));
			end
			if (ph == 2)
				hold_arm <= 1'b1;
			drain_lane();
		end

		if (awaited_resps.size() > 0) begin
			$error("%0d expected results never arrived", awaited_resps.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
